@@ rtl/core/rsqe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Road segment quad expander package
// Shared types and constants for the quad expander pipeline.
// ----------------------------------------------------------------------------
package rsqe_pkg;

   // fixed-point format of coordinates
   localparam int FRAC_BITS = 16;

   // squared length at or below which a segment counts as degenerate (length 0.0001)
   localparam logic [60:0] EPS_LEN2 =
      61'((64'd1 << (2 * FRAC_BITS)) / 64'd100000000);

   // tile size after reset, 64.0 in Q16.16
   localparam logic [30:0] TILE_SIZE_RESET = 31'd4194304;

   // 1.0 in Q30
   localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

   // pipeline geometry
   localparam int NORM_STEPS = 5;
   localparam int ROOT_BITS  = 31;
   localparam int QUO_BITS   = 32;

   // one input request, last field in the lowest bits
   typedef struct packed {
      logic [30:0] road_width;
      logic [31:0] stop_z;
      logic [31:0] stop_x;
      logic [31:0] start_z;
      logic [31:0] start_x;
   } rsqe_seg_type;

   // one result, last field in the lowest bits
   typedef struct packed {
      logic [15:0] tile_row;
      logic [15:0] tile_col;
      logic [31:0] left_stop_z;
      logic [31:0] left_stop_x;
      logic [31:0] right_stop_z;
      logic [31:0] right_stop_x;
      logic [31:0] right_start_z;
      logic [31:0] right_start_x;
      logic [31:0] left_start_z;
      logic [31:0] left_start_x;
   } rsqe_rsp_type;

   // data carried from the front end through the square root
   typedef struct packed {
      rsqe_seg_type seg;
      logic [30:0]  ax;
      logic [30:0]  az;
      logic         degen;
      logic         neg_dx;
      logic         neg_dz;
      logic [32:0]  mag_x;
      logic [32:0]  mag_z;
      logic         neg_x;
      logic         neg_z;
      logic [31:0]  tdiv;
   } rsqe_side_type;

   // data carried beside the x unit divider
   typedef struct packed {
      logic        degen;
      logic        neg_dx;
      logic [31:0] sx;
      logic [31:0] sz;
      logic [30:0] w;
   } rsqe_xside_type;

   // data carried beside the z unit divider
   typedef struct packed {
      logic        neg_dz;
      logic [31:0] ex;
      logic [31:0] ez;
   } rsqe_zside_type;

endpackage

@@ rtl/core/rsqe_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad expander front end
// Deltas, magnitudes, midpoint sums, squared length, degenerate test and
// even-shift normalization of the squared length.
// ----------------------------------------------------------------------------
module rsqe_front import rsqe_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  rsqe_seg_type  in_seg,
   input  logic [30:0]   tile_size,
   output logic          out_valid,
   output logic [60:0]   out_s,
   output rsqe_side_type out_side
);

   // stage 1: deltas and midpoint sums
   logic [32:0]   dx_c, dz_c, nx_c, nz_c;
   rsqe_side_type side1_in, side1_ff;
   logic [32:0]   ax1_in, az1_in, ax1_ff, az1_ff;
   logic          v1_ff;

   always_comb begin
      dx_c = {in_seg.stop_x[31], in_seg.stop_x} - {in_seg.start_x[31], in_seg.start_x};
      dz_c = {in_seg.stop_z[31], in_seg.stop_z} - {in_seg.start_z[31], in_seg.start_z};
      nx_c = {in_seg.start_x[31], in_seg.start_x} + {in_seg.stop_x[31], in_seg.stop_x};
      nz_c = {in_seg.start_z[31], in_seg.start_z} + {in_seg.stop_z[31], in_seg.stop_z};
      ax1_in = dx_c[32] ? 33'd0 - dx_c : dx_c;
      az1_in = dz_c[32] ? 33'd0 - dz_c : dz_c;
      side1_in        = '0;
      side1_in.seg    = in_seg;
      side1_in.neg_dx = dx_c[32];
      side1_in.neg_dz = dz_c[32];
      side1_in.neg_x  = nx_c[32];
      side1_in.neg_z  = nz_c[32];
      side1_in.mag_x  = nx_c[32] ? 33'd0 - nx_c : nx_c;
      side1_in.mag_z  = nz_c[32] ? 33'd0 - nz_c : nz_c;
      // a zero tile size counts as one raw unit
      side1_in.tdiv   = (tile_size == 31'd0) ? 32'd2 : {tile_size, 1'b0};
   end

   // stage 2: shift both magnitudes right until they fit in 30 bits
   logic [32:0]   or_c, axs_c, azs_c;
   logic [1:0]    sh_c;
   rsqe_side_type side2_in, side2_ff;
   logic          big2_ff, v2_ff;

   always_comb begin
      or_c = ax1_ff | az1_ff;
      if (or_c[32]) begin
         sh_c = 2'd3;
      end else if (or_c[31]) begin
         sh_c = 2'd2;
      end else if (or_c[30]) begin
         sh_c = 2'd1;
      end else begin
         sh_c = 2'd0;
      end
      axs_c = ax1_ff >> sh_c;
      azs_c = az1_ff >> sh_c;
      side2_in    = side1_ff;
      side2_in.ax = {1'b0, axs_c[29:0]};
      side2_in.az = {1'b0, azs_c[29:0]};
   end

   // stage 3: squares
   logic [59:0]   sqx3_ff, sqz3_ff;
   rsqe_side_type side3_ff;
   logic          big3_ff, v3_ff;

   // stage 4: squared length and degenerate test
   logic [60:0]   s4_in, s4_ff;
   rsqe_side_type side4_in, side4_ff;
   logic          v4_ff;

   always_comb begin
      s4_in          = {1'b0, sqx3_ff} + {1'b0, sqz3_ff};
      side4_in       = side3_ff;
      side4_in.degen = !big3_ff && (s4_in <= EPS_LEN2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff <= side1_in;
         ax1_ff   <= ax1_in;
         az1_ff   <= az1_in;
         side2_ff <= side2_in;
         big2_ff  <= |or_c[32:30];
         sqx3_ff  <= side2_ff.ax[29:0] * side2_ff.ax[29:0];
         sqz3_ff  <= side2_ff.az[29:0] * side2_ff.az[29:0];
         side3_ff <= side2_ff;
         big3_ff  <= big2_ff;
         s4_ff    <= s4_in;
         side4_ff <= side4_in;
      end
   end

   // normalization: shift by 32, 16, 8, 4, 2 bits while the top stays clear
   logic [60:0]   ns_src [0:NORM_STEPS-1];
   rsqe_side_type nside_src [0:NORM_STEPS-1];
   logic          nv_src [0:NORM_STEPS-1];
   logic [60:0]   ns_in [0:NORM_STEPS-1];
   rsqe_side_type nside_in [0:NORM_STEPS-1];
   logic [60:0]   ns_ff [0:NORM_STEPS-1];
   rsqe_side_type nside_ff [0:NORM_STEPS-1];
   logic          nv_ff [0:NORM_STEPS-1];

   always_comb begin
      ns_src[0]    = s4_ff;
      nside_src[0] = side4_ff;
      nv_src[0]    = v4_ff;
      for (int i = 1; i < NORM_STEPS; i++) begin
         ns_src[i]    = ns_ff[i-1];
         nside_src[i] = nside_ff[i-1];
         nv_src[i]    = nv_ff[i-1];
      end
      for (int i = 0; i < NORM_STEPS; i++) begin
         nside_in[i] = nside_src[i];
         if ((ns_src[i] >> (61 - (2 << (NORM_STEPS - 1 - i)))) == 61'd0) begin
            ns_in[i]       = ns_src[i] << (2 << (NORM_STEPS - 1 - i));
            nside_in[i].ax = nside_src[i].ax << (1 << (NORM_STEPS - 1 - i));
            nside_in[i].az = nside_src[i].az << (1 << (NORM_STEPS - 1 - i));
         end else begin
            ns_in[i] = ns_src[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NORM_STEPS; i++) nv_ff[i] <= 1'b0;
      end else if (en) begin
         for (int i = 0; i < NORM_STEPS; i++) nv_ff[i] <= nv_src[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NORM_STEPS; i++) begin
            ns_ff[i]    <= ns_in[i];
            nside_ff[i] <= nside_in[i];
         end
      end
   end

   assign out_valid = nv_ff[NORM_STEPS-1];
   assign out_s     = ns_ff[NORM_STEPS-1];
   assign out_side  = nside_ff[NORM_STEPS-1];

endmodule

@@ rtl/core/rsqe_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad expander square root
// Pipelined digit-by-digit integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rsqe_sqrt import rsqe_pkg::*; #(
   parameter int SIDE_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [60:0]          in_s,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output logic [ROOT_BITS-1:0] out_root,
   output logic [SIDE_W-1:0]    out_side
);

   logic [61:0]          s_src [0:ROOT_BITS-1];
   logic [ROOT_BITS-1:0] root_src [0:ROOT_BITS-1];
   logic [32:0]          rem_src [0:ROOT_BITS-1];
   logic [SIDE_W-1:0]    side_src [0:ROOT_BITS-1];
   logic                 v_src [0:ROOT_BITS-1];
   logic [ROOT_BITS-1:0] root_in [0:ROOT_BITS-1];
   logic [32:0]          rem_in [0:ROOT_BITS-1];
   logic [61:0]          s_ff [0:ROOT_BITS-1];
   logic [ROOT_BITS-1:0] root_ff [0:ROOT_BITS-1];
   logic [32:0]          rem_ff [0:ROOT_BITS-1];
   logic [SIDE_W-1:0]    side_ff [0:ROOT_BITS-1];
   logic                 v_ff [0:ROOT_BITS-1];

   // bring down one digit pair per stage and try root*4+1
   always_comb begin
      logic [34:0] t;
      logic [34:0] trial;
      logic [34:0] diff;
      logic        ge;
      s_src[0]    = {1'b0, in_s};
      root_src[0] = '0;
      rem_src[0]  = '0;
      side_src[0] = in_side;
      v_src[0]    = in_valid;
      for (int i = 1; i < ROOT_BITS; i++) begin
         s_src[i]    = s_ff[i-1];
         root_src[i] = root_ff[i-1];
         rem_src[i]  = rem_ff[i-1];
         side_src[i] = side_ff[i-1];
         v_src[i]    = v_ff[i-1];
      end
      for (int i = 0; i < ROOT_BITS; i++) begin
         t          = {rem_src[i], s_src[i][2*(ROOT_BITS-1-i) +: 2]};
         trial      = {2'b00, root_src[i], 2'b01};
         ge         = t >= trial;
         diff       = t - trial;
         rem_in[i]  = ge ? diff[32:0] : t[32:0];
         root_in[i] = {root_src[i][ROOT_BITS-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROOT_BITS; i++) v_ff[i] <= 1'b0;
      end else if (en) begin
         for (int i = 0; i < ROOT_BITS; i++) v_ff[i] <= v_src[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < ROOT_BITS; i++) begin
            s_ff[i]    <= s_src[i];
            root_ff[i] <= root_in[i];
            rem_ff[i]  <= rem_in[i];
            side_ff[i] <= side_src[i];
         end
      end
   end

   assign out_valid = v_ff[ROOT_BITS-1];
   assign out_root  = root_ff[ROOT_BITS-1];
   assign out_side  = side_ff[ROOT_BITS-1];

endmodule

@@ rtl/core/rsqe_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad expander divider
// Pipelined restoring divider, one quotient bit per stage. The numerator's
// bits above the quotient width must form a value below the divisor.
// ----------------------------------------------------------------------------
module rsqe_div #(
   parameter int NW     = 62,
   parameter int DW     = 31,
   parameter int QW     = 32,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NW-1:0]     in_n,
   input  logic [DW-1:0]     in_d,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QW-1:0]     out_q,
   output logic              out_rem_nz,
   output logic [SIDE_W-1:0] out_side
);

   logic [QW-1:0]     n_src [0:QW-1];
   logic [DW-1:0]     d_src [0:QW-1];
   logic [DW-1:0]     r_src [0:QW-1];
   logic [QW-1:0]     q_src [0:QW-1];
   logic [SIDE_W-1:0] side_src [0:QW-1];
   logic              v_src [0:QW-1];
   logic [DW-1:0]     r_in [0:QW-1];
   logic [QW-1:0]     q_in [0:QW-1];
   logic [QW-1:0]     n_ff [0:QW-1];
   logic [DW-1:0]     d_ff [0:QW-1];
   logic [DW-1:0]     r_ff [0:QW-1];
   logic [QW-1:0]     q_ff [0:QW-1];
   logic [SIDE_W-1:0] side_ff [0:QW-1];
   logic              v_ff [0:QW-1];

   // shift in one numerator bit and subtract the divisor where it fits
   always_comb begin
      logic [DW:0] t;
      logic [DW:0] diff;
      logic        ge;
      n_src[0]    = in_n[QW-1:0];
      d_src[0]    = in_d;
      r_src[0]    = DW'(in_n >> QW);
      q_src[0]    = '0;
      side_src[0] = in_side;
      v_src[0]    = in_valid;
      for (int i = 1; i < QW; i++) begin
         n_src[i]    = n_ff[i-1];
         d_src[i]    = d_ff[i-1];
         r_src[i]    = r_ff[i-1];
         q_src[i]    = q_ff[i-1];
         side_src[i] = side_ff[i-1];
         v_src[i]    = v_ff[i-1];
      end
      for (int i = 0; i < QW; i++) begin
         t       = {r_src[i], n_src[i][QW-1-i]};
         ge      = t >= {1'b0, d_src[i]};
         diff    = t - {1'b0, d_src[i]};
         r_in[i] = ge ? diff[DW-1:0] : t[DW-1:0];
         q_in[i] = {q_src[i][QW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QW; i++) v_ff[i] <= 1'b0;
      end else if (en) begin
         for (int i = 0; i < QW; i++) v_ff[i] <= v_src[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < QW; i++) begin
            n_ff[i]    <= n_src[i];
            d_ff[i]    <= d_src[i];
            r_ff[i]    <= r_in[i];
            q_ff[i]    <= q_in[i];
            side_ff[i] <= side_src[i];
         end
      end
   end

   assign out_valid  = v_ff[QW-1];
   assign out_q      = q_ff[QW-1];
   assign out_rem_nz = |r_ff[QW-1];
   assign out_side   = side_ff[QW-1];

endmodule

@@ rtl/core/rsqe_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad expander back end
// Scales the unit vector by half the width, forms the four saturated corners
// and the saturated tile indexes, and holds the result register.
// ----------------------------------------------------------------------------
module rsqe_back import rsqe_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  logic [31:0]    in_qx,
   input  logic [31:0]    in_qz,
   input  logic [31:0]    in_qcol,
   input  logic [31:0]    in_qrow,
   input  logic           in_col_nz,
   input  logic           in_row_nz,
   input  logic           in_neg_x,
   input  logic           in_neg_z,
   input  rsqe_xside_type in_xs,
   input  rsqe_zside_type in_zs,
   output logic           out_valid,
   output rsqe_rsp_type   out_rsp,
   output logic           out_degen
);

   // floor quotient from magnitude quotient, saturated to 16 bits
   function automatic logic [15:0] tile_sat(logic [31:0] q, logic neg, logic nz);
      logic [32:0] v;
      logic [15:0] r;
      v = {1'b0, q} + {32'd0, nz};
      if (neg) begin
         r = (v > 33'd32768) ? 16'h8000 : 16'd0 - v[15:0];
      end else begin
         r = (q > 32'd32767) ? 16'h7fff : q[15:0];
      end
      return r;
   endfunction

   // a + b or a - b, saturated to 32-bit signed
   function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b, logic sub);
      logic [32:0] r;
      r = sub ? {a[31], a} - {b[31], b} : {a[31], a} + {b[31], b};
      if (r[32] != r[31]) begin
         return r[32] ? 32'h8000_0000 : 32'h7fff_ffff;
      end
      return r[31:0];
   endfunction

   // stage 1: clamp unit components and multiply by the width
   logic [30:0]    ux_c, uz_c;
   logic [61:0]    px1_ff, pz1_ff;
   logic [15:0]    col1_ff, row1_ff;
   rsqe_xside_type xs1_ff;
   rsqe_zside_type zs1_ff;
   logic           v1_ff;

   always_comb begin
      ux_c = (in_qx > ONE_Q30) ? ONE_Q30[30:0] : in_qx[30:0];
      uz_c = (in_qz > ONE_Q30) ? ONE_Q30[30:0] : in_qz[30:0];
   end

   // stage 2: round to half width and turn a quarter left
   logic [62:0]    rx_c, rz_c;
   logic [31:0]    mx_c, mz_c;
   logic [31:0]    ox2_ff, oz2_ff;
   logic [15:0]    col2_ff, row2_ff;
   rsqe_xside_type xs2_ff;
   rsqe_zside_type zs2_ff;
   logic           v2_ff;

   always_comb begin
      rx_c = {1'b0, px1_ff} + 63'(ONE_Q30);
      rz_c = {1'b0, pz1_ff} + 63'(ONE_Q30);
      mx_c = rx_c[62:31];
      mz_c = rz_c[62:31];
   end

   // stage 3: corners
   rsqe_rsp_type rsp_in;

   always_comb begin
      rsp_in.left_start_x  = sat_add(xs2_ff.sx, ox2_ff, 1'b0);
      rsp_in.left_start_z  = sat_add(xs2_ff.sz, oz2_ff, 1'b0);
      rsp_in.right_start_x = sat_add(xs2_ff.sx, ox2_ff, 1'b1);
      rsp_in.right_start_z = sat_add(xs2_ff.sz, oz2_ff, 1'b1);
      rsp_in.right_stop_x  = sat_add(zs2_ff.ex, ox2_ff, 1'b1);
      rsp_in.right_stop_z  = sat_add(zs2_ff.ez, oz2_ff, 1'b1);
      rsp_in.left_stop_x   = sat_add(zs2_ff.ex, ox2_ff, 1'b0);
      rsp_in.left_stop_z   = sat_add(zs2_ff.ez, oz2_ff, 1'b0);
      // drop the corners of a degenerate segment
      if (xs2_ff.degen) begin
         rsp_in.left_start_x  = '0;
         rsp_in.left_start_z  = '0;
         rsp_in.right_start_x = '0;
         rsp_in.right_start_z = '0;
         rsp_in.right_stop_x  = '0;
         rsp_in.right_stop_z  = '0;
         rsp_in.left_stop_x   = '0;
         rsp_in.left_stop_z   = '0;
      end
      rsp_in.tile_col = col2_ff;
      rsp_in.tile_row = row2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         out_valid <= 1'b0;
      end else if (en) begin
         v1_ff     <= in_valid;
         v2_ff     <= v1_ff;
         out_valid <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px1_ff    <= ux_c * in_xs.w;
         pz1_ff    <= uz_c * in_xs.w;
         col1_ff   <= tile_sat(in_qcol, in_neg_x, in_col_nz);
         row1_ff   <= tile_sat(in_qrow, in_neg_z, in_row_nz);
         xs1_ff    <= in_xs;
         zs1_ff    <= in_zs;
         ox2_ff    <= zs1_ff.neg_dz ? mz_c : 32'd0 - mz_c;
         oz2_ff    <= xs1_ff.neg_dx ? 32'd0 - mx_c : mx_c;
         col2_ff   <= col1_ff;
         row2_ff   <= row1_ff;
         xs2_ff    <= xs1_ff;
         zs2_ff    <= zs1_ff;
         out_rsp   <= rsp_in;
         out_degen <= xs2_ff.degen;
      end
   end

endmodule

@@ rtl/core/road_segment_quad_expander.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Road segment quad expander
// Expands a road segment into the four corners of a quad of its width and
// bins the segment midpoint into a square map tile.
//
// Usage:
//   req_* carries one segment request per handshake; rsp_* returns exactly
//   one result per request, in order. csr_* writes the tile size; it is
//   always ready. It must be written only while the block is idle; the
//   block does not enforce this. The pipeline has 9 front-end stages,
//   31 square-root stages (one root bit each), one numerator stage,
//   32 divider stages (one quotient bit each) and 3 back-end stages.
//   Throughput is one request per cycle while results are taken; the whole
//   pipeline moves on a single advance enable.
//   When the receiver stalls with a result waiting, every stage holds,
//   empty slots included, and req_tready drops until the result is taken.
//   Reset clears all stage valid bits and loads a tile size of 64.0.
// ----------------------------------------------------------------------------
module road_segment_quad_expander import rsqe_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   // request: start_x, start_z, stop_x, stop_z, road_width, zero pad
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [159:0] req_tdata,
   // result: left_start_x/z, right_start_x/z, right_stop_x/z,
   //         left_stop_x/z, tile_col, tile_row
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [287:0] rsp_tdata,
   // result flag: degenerate
   output logic         rsp_tuser,
   // tile size register
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [30:0]  csr_data
);

   logic adv;

   // advance the whole pipeline unless a result is stuck at the output
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   // tile size register
   logic [30:0] tile_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_size_ff <= TILE_SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         tile_size_ff <= csr_data;
      end
   end

   // front end
   rsqe_seg_type  seg;
   logic          fr_valid;
   logic [60:0]   fr_s;
   rsqe_side_type fr_side;

   assign seg = rsqe_seg_type'(req_tdata[158:0]);

   rsqe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (req_tvalid),
      .in_seg    (seg),
      .tile_size (tile_size_ff),
      .out_valid (fr_valid),
      .out_s     (fr_s),
      .out_side  (fr_side)
   );

   // square root of the normalized squared length
   logic                        sq_valid;
   logic [ROOT_BITS-1:0]        sq_root;
   logic [$bits(rsqe_side_type)-1:0] sq_side_vec;
   rsqe_side_type               sq_side;

   rsqe_sqrt #(
      .SIDE_W ($bits(rsqe_side_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (fr_valid),
      .in_s      (fr_s),
      .in_side   (fr_side),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side_vec)
   );

   assign sq_side = rsqe_side_type'(sq_side_vec);

   // numerators: a * 2^30 plus half the length, for round to nearest
   logic [61:0]          m_nx_ff, m_nz_ff;
   logic [ROOT_BITS-1:0] m_len_ff;
   rsqe_side_type        m_side_ff;
   logic                 m_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (adv) begin
         m_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_nx_ff   <= {1'b0, sq_side.ax, 30'd0} + {32'd0, sq_root[ROOT_BITS-1:1]};
         m_nz_ff   <= {1'b0, sq_side.az, 30'd0} + {32'd0, sq_root[ROOT_BITS-1:1]};
         m_len_ff  <= sq_root;
         m_side_ff <= sq_side;
      end
   end

   // side data for the dividers
   rsqe_xside_type xs_in, xs_out;
   rsqe_zside_type zs_in, zs_out;
   logic [$bits(rsqe_xside_type)-1:0] xs_vec;
   logic [$bits(rsqe_zside_type)-1:0] zs_vec;

   always_comb begin
      xs_in.degen  = m_side_ff.degen;
      xs_in.neg_dx = m_side_ff.neg_dx;
      xs_in.sx     = m_side_ff.seg.start_x;
      xs_in.sz     = m_side_ff.seg.start_z;
      xs_in.w      = m_side_ff.seg.road_width;
      zs_in.neg_dz = m_side_ff.neg_dz;
      zs_in.ex     = m_side_ff.seg.stop_x;
      zs_in.ez     = m_side_ff.seg.stop_z;
   end

   assign xs_out = rsqe_xside_type'(xs_vec);
   assign zs_out = rsqe_zside_type'(zs_vec);

   // unit vector and tile dividers, side by side
   logic              dx_valid, dz_valid, dc_valid, dr_valid;
   logic [QUO_BITS-1:0] qx, qz, qcol, qrow;
   logic              col_nz, row_nz, neg_x, neg_z;

   rsqe_div #(
      .NW (62), .DW (ROOT_BITS), .QW (QUO_BITS), .SIDE_W ($bits(rsqe_xside_type))
   ) u_div_x (
      .clock      (clock),
      .reset      (reset),
      .en         (adv),
      .in_valid   (m_valid_ff),
      .in_n       (m_nx_ff),
      .in_d       (m_len_ff),
      .in_side    (xs_in),
      .out_valid  (dx_valid),
      .out_q      (qx),
      .out_rem_nz (),
      .out_side   (xs_vec)
   );

   rsqe_div #(
      .NW (62), .DW (ROOT_BITS), .QW (QUO_BITS), .SIDE_W ($bits(rsqe_zside_type))
   ) u_div_z (
      .clock      (clock),
      .reset      (reset),
      .en         (adv),
      .in_valid   (m_valid_ff),
      .in_n       (m_nz_ff),
      .in_d       (m_len_ff),
      .in_side    (zs_in),
      .out_valid  (dz_valid),
      .out_q      (qz),
      .out_rem_nz (),
      .out_side   (zs_vec)
   );

   rsqe_div #(
      .NW (33), .DW (32), .QW (QUO_BITS), .SIDE_W (1)
   ) u_div_col (
      .clock      (clock),
      .reset      (reset),
      .en         (adv),
      .in_valid   (m_valid_ff),
      .in_n       (m_side_ff.mag_x),
      .in_d       (m_side_ff.tdiv),
      .in_side    (m_side_ff.neg_x),
      .out_valid  (dc_valid),
      .out_q      (qcol),
      .out_rem_nz (col_nz),
      .out_side   (neg_x)
   );

   rsqe_div #(
      .NW (33), .DW (32), .QW (QUO_BITS), .SIDE_W (1)
   ) u_div_row (
      .clock      (clock),
      .reset      (reset),
      .en         (adv),
      .in_valid   (m_valid_ff),
      .in_n       (m_side_ff.mag_z),
      .in_d       (m_side_ff.tdiv),
      .in_side    (m_side_ff.neg_z),
      .out_valid  (dr_valid),
      .out_q      (qrow),
      .out_rem_nz (row_nz),
      .out_side   (neg_z)
   );

   // back end and result register
   rsqe_rsp_type rsp;

   rsqe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (dx_valid && dz_valid && dc_valid && dr_valid),
      .in_qx     (qx),
      .in_qz     (qz),
      .in_qcol   (qcol),
      .in_qrow   (qrow),
      .in_col_nz (col_nz),
      .in_row_nz (row_nz),
      .in_neg_x  (neg_x),
      .in_neg_z  (neg_z),
      .in_xs     (xs_out),
      .in_zs     (zs_out),
      .out_valid (rsp_tvalid),
      .out_rsp   (rsp),
      .out_degen (rsp_tuser)
   );

   assign rsp_tdata = rsp;

endmodule
